// ===== hw/rtl/tga_pkg.sv =====
// Shared types, constants and helper functions for the TGA pixel decoder.
package tga_pkg;

  localparam int CountWidth = 32;
  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam logic [7:0] HdrRunMask   = 8'h7F;
  localparam logic [7:0] HdrRepeatBit = 8'h80;

  typedef enum logic [1:0] {
    REG_COMPRESSED_MODE = 2'd0,
    REG_BPP_CODE        = 2'd1,
    REG_TOTAL_PIXELS    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BPP_GREY = 2'd0,
    BPP_BGR  = 2'd1,
    BPP_BGRA = 2'd2
  } bpp_code_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic calc;
    logic emit;
  } tga_cmd_t;

  typedef struct packed {
    logic pixel_complete;
    logic out_free;
    logic last_result;
  } tga_status_t;

  // Bytes per pixel for a size code; unused code behaves like four bytes.
  function automatic logic [2:0] pixel_size(input logic [1:0] code);
    logic [2:0] size;
    case (code)
      BPP_GREY: size = 3'd1;
      BPP_BGR:  size = 3'd3;
      default:  size = 3'd4;
    endcase
    return size;
  endfunction

  // Swap BGR(A) into RGB(A); grey keeps the low byte only.
  function automatic logic [31:0] reorder_pixel(input logic [31:0] raw,
                                                input logic [2:0] size);
    logic [31:0] pix;
    if (size == 3'd1) begin
      pix = {24'd0, raw[7:0]};
    end else begin
      pix = {(size == 3'd4) ? raw[31:24] : 8'd0, raw[7:0], raw[15:8], raw[23:16]};
    end
    return pix;
  endfunction

endpackage

// ===== hw/rtl/tga_in_if.sv =====
// Input byte channel.
interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink (input valid, input data_byte, input start_of_image, output ready);
endinterface

// ===== hw/rtl/tga_out_if.sv =====
// Pixel result channel.
interface tga_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_first;
  logic [31:0] pixel_second;
  logic [1:0]  pixel_count;
  logic        run_last;
  logic        image_end;
  logic        overrun;

  modport source (output valid, output pixel_first, output pixel_second,
                  output pixel_count, output run_last, output image_end,
                  output overrun, input ready);
  modport sink (input valid, input pixel_first, input pixel_second,
                input pixel_count, input run_last, input image_end,
                input overrun, output ready);
endinterface

// ===== hw/rtl/tga_cfg_if.sv =====
// Configuration write channel.
interface tga_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tga_ctrl.sv =====
// Controller state machine: byte intake, room calculation, result emission.
module tga_ctrl
  import tga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  tga_status_t status,
  output tga_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.pixel_complete) state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_result) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/tga_dp.sv =====
// Datapath: config registers, packet state, pixel assembly, counting, output register.
module tga_dp
  import tga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tga_cmd_t    cmd,
  output tga_status_t status,
  input  logic [7:0]  in_byte,
  input  logic        in_start,
  tga_cfg_if.sink     cfg,
  tga_out_if.source   pixels
);

  // Configuration
  logic                  compressed_mode;
  logic [1:0]            bpp_code;
  logic [31:0]           total_pixels;

  // Packet and pixel state
  logic                  expect_header;
  logic                  packet_is_repeat;
  logic [7:0]            run_remaining;
  logic [1:0]            byte_in_pixel;
  logic [31:0]           pixel_assembly;
  logic [CountWidth-1:0] pixels_done;

  // Pending emission
  logic [31:0]           emit_pixel;
  logic [7:0]            emit_count;
  logic [7:0]            kept;
  logic                  emit_overrun;

  // Output register
  logic                  out_valid;
  logic [31:0]           out_first;
  logic [31:0]           out_second;
  logic [1:0]            out_count;
  logic                  out_run_last;
  logic                  out_image_end;
  logic                  out_overrun;

  logic [CountWidth-1:0] total_eff;
  logic [2:0]            size;

  // Accept-time view of state after an optional start-of-image clear
  logic                  eh_cur;
  logic                  rep_cur;
  logic [7:0]            rr_cur;
  logic [1:0]            bip_cur;
  logic [31:0]           asm_cur;

  logic                  is_header;
  logic [31:0]           asm_new;
  logic [1:0]            bip_inc;
  logic                  complete;
  logic [7:0]            rr_one;

  logic                  eh_next;
  logic                  rep_next;
  logic [7:0]            rr_next;
  logic [1:0]            bip_next;
  logic [31:0]           asm_next;
  logic [7:0]            count_next;

  logic [CountWidth-1:0] room;
  logic [7:0]            kept_calc;

  logic [1:0]            take;
  logic [7:0]            kept_rem;
  logic [CountWidth-1:0] done_inc;

  assign total_eff = (total_pixels >= 32'(CountMax)) ? CountMax
                                                     : total_pixels[CountWidth-1:0];
  assign size = pixel_size(bpp_code);

  assign cfg.ready = 1'b1;

  always_comb begin
    eh_cur  = in_start ? 1'b1   : expect_header;
    rep_cur = in_start ? 1'b0   : packet_is_repeat;
    rr_cur  = in_start ? 8'd0   : run_remaining;
    bip_cur = in_start ? 2'd0   : byte_in_pixel;
    asm_cur = in_start ? 32'd0  : pixel_assembly;

    is_header = compressed_mode && eh_cur;
    asm_new   = asm_cur | ({24'd0, in_byte} << {bip_cur, 3'd0});
    bip_inc   = bip_cur + 2'd1;
    complete  = !is_header && ((bip_inc == 2'd0) || ({1'b0, bip_inc} >= size));
    rr_one    = (rr_cur == 8'd0) ? 8'd1 : rr_cur;

    eh_next    = eh_cur;
    rep_next   = rep_cur;
    rr_next    = rr_cur;
    bip_next   = bip_inc;
    asm_next   = asm_new;
    count_next = 8'd1;

    if (is_header) begin
      rr_next  = {1'b0, in_byte[6:0] & HdrRunMask[6:0]} + 8'd1;
      rep_next = (in_byte & HdrRepeatBit) != 8'd0;
      eh_next  = 1'b0;
      bip_next = 2'd0;
      asm_next = 32'd0;
    end else if (complete) begin
      bip_next = 2'd0;
      asm_next = 32'd0;
      if (compressed_mode) begin
        if (rep_cur) begin
          count_next = rr_one;
          rr_next    = 8'd0;
          eh_next    = 1'b1;
        end else begin
          rr_next = rr_one - 8'd1;
          eh_next = (rr_one == 8'd1);
        end
      end
    end
  end

  // Room left before the total; clamp the run to it
  assign room = (total_eff > pixels_done) ? (total_eff - pixels_done) : '0;
  assign kept_calc = ({{(CountWidth-8){1'b0}}, emit_count} < room) ? emit_count
                                                                   : room[7:0];

  assign take     = (kept >= 8'd2) ? 2'd2 : 2'd1;
  assign kept_rem = kept - {6'd0, take};
  assign done_inc = pixels_done + {{(CountWidth-2){1'b0}}, take};

  assign status.pixel_complete = complete;
  assign status.out_free       = !out_valid || pixels.ready;
  assign status.last_result    = (kept <= 8'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed_mode  <= 1'b1;
      bpp_code         <= BPP_BGR;
      total_pixels     <= 32'd1;
      expect_header    <= 1'b1;
      packet_is_repeat <= 1'b0;
      run_remaining    <= 8'd0;
      byte_in_pixel    <= 2'd0;
      pixel_assembly   <= 32'd0;
      pixels_done      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_COMPRESSED_MODE: compressed_mode <= cfg.data[0];
          REG_BPP_CODE:        bpp_code        <= cfg.data[1:0];
          REG_TOTAL_PIXELS:    total_pixels    <= cfg.data;
          default: ;
        endcase
      end

      if (cmd.accept) begin
        expect_header    <= eh_next;
        packet_is_repeat <= rep_next;
        run_remaining    <= rr_next;
        byte_in_pixel    <= bip_next;
        pixel_assembly   <= asm_next;
        if (in_start) pixels_done <= '0;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (kept != 8'd0) pixels_done <= done_inc;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && complete) begin
      emit_pixel <= reorder_pixel(asm_new, size);
      emit_count <= count_next;
    end
    if (cmd.calc) begin
      kept         <= kept_calc;
      emit_overrun <= kept_calc < emit_count;
    end
    if (cmd.emit) begin
      if (kept == 8'd0) begin
        // No room left: one empty result flags the drop
        out_first     <= 32'd0;
        out_second    <= 32'd0;
        out_count     <= 2'd0;
        out_run_last  <= 1'b1;
        out_image_end <= pixels_done >= total_eff;
        out_overrun   <= 1'b1;
      end else begin
        kept          <= kept_rem;
        out_first     <= emit_pixel;
        out_second    <= (take == 2'd2) ? emit_pixel : 32'd0;
        out_count     <= take;
        out_run_last  <= (kept_rem == 8'd0);
        out_image_end <= done_inc >= total_eff;
        out_overrun   <= emit_overrun;
      end
    end
  end

  assign pixels.valid        = out_valid;
  assign pixels.pixel_first  = out_first;
  assign pixels.pixel_second = out_second;
  assign pixels.pixel_count  = out_count;
  assign pixels.run_last     = out_run_last;
  assign pixels.image_end    = out_image_end;
  assign pixels.overrun      = out_overrun;

endmodule

// ===== hw/rtl/tga_rle_pixel_decoder.sv =====
// Top level of the TGA image-data pixel decoder.
//
// Channels: "data" takes one byte of the TGA image-data section per request,
// with start_of_image marking the first byte of a new image (clears counters
// and packet state). "pixels" delivers results of up to two packed pixels
// (R/grey in 7:0, G 15:8, B 23:16, A 31:24). "cfg" writes compressed_mode
// (index 0), bytes_per_pixel_code (index 1) and total_pixels (index 2); it is
// always ready and should be written only while the block is idle.
// Flow: a packet header byte or a byte that does not finish a pixel is only
// taken in. A byte that finishes a pixel is taken in, then checked for room
// against the total, then emitted as results of up to two pixels each, so a
// 128-pixel repeat run gives 64 results. The single result register of the
// datapath lets one result leave per cycle while the receiver takes it.
// A held result does not block intake of the next byte once emission is over;
// while results of a run are still pending, the input is not ready, and a
// stalled receiver simply holds the result register and the run in place.
// Reset (rst, synchronous) restores run-length mode, three-byte BGR pixels,
// a total of one pixel, and clears the packet state and the pixels-done count.
module tga_rle_pixel_decoder
  import tga_pkg::*;
(
  input logic       clk,
  input logic       rst,
  tga_in_if.sink    data,
  tga_out_if.source pixels,
  tga_cfg_if.sink   cfg
);

  tga_cmd_t    cmd;
  tga_status_t status;

  assign data.ready = cmd.in_ready;

  tga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (data.valid),
    .status   (status),
    .cmd      (cmd)
  );

  tga_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_byte  (data.data_byte),
    .in_start (data.start_of_image),
    .cfg      (cfg),
    .pixels   (pixels)
  );

endmodule

// ===== dv/tga_rle_pixel_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the TGA run-length pixel decoder.
module tga_rle_pixel_decoder_test
  import tga_pkg::*;
();

  localparam int unsigned RandomItems  = 400;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 10_000_000;
  localparam int unsigned ReportLimit  = 10;

  typedef struct packed {
    logic [31:0] pixel_first;
    logic [31:0] pixel_second;
    logic [1:0]  pixel_count;
    logic        run_last;
    logic        image_end;
    logic        overrun;
  } pix_result_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_reg_t    reg_idx;
    logic [31:0] value;
    logic [7:0]  data_byte;
    logic        sof;
    logic        typed;
    pix_result_t want;
  } directed_row_t;

  localparam pix_result_t NoResult = '0;
  localparam pix_result_t Dropped  = '{32'd0, 32'd0, 2'd0, 1'b1, 1'b1, 1'b1};

  localparam int NumDirected = 33;
  localparam directed_row_t DirectedRows [NumDirected] = '{
    // reset settings: run-length, BGR, total of one pixel
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h80, 1'b1, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'hFF, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h5A, 1'b0, 1'b1,
      '{32'h0000_FF5A, 32'd0, 2'd1, 1'b1, 1'b1, 1'b0}},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h81, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h11, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h22, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h33, 1'b0, 1'b1, Dropped},
    // zero total, grey, uncompressed: every pixel dropped
    '{1'b1, REG_TOTAL_PIXELS, 32'd0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b1, REG_BPP_CODE, 32'd0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b1, REG_COMPRESSED_MODE, 32'd0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'hFF, 1'b1, 1'b1, Dropped},
    // full-scale total, unused size code acts as four bytes
    '{1'b1, REG_TOTAL_PIXELS, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b1, REG_BPP_CODE, 32'd3, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h01, 1'b1, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h02, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h03, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h04, 1'b0, 1'b1,
      '{32'h0401_0203, 32'd0, 2'd1, 1'b1, 1'b0, 1'b0}},
    // run-length BGRA, longest repeat run
    '{1'b1, REG_COMPRESSED_MODE, 32'd1, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b1, REG_BPP_CODE, 32'd2, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'hFF, 1'b1, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'hFF, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h80, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h7F, 1'b0, 1'b0, NoResult},
    // grey literal run that reaches the total, then a drop
    '{1'b1, REG_BPP_CODE, 32'd0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b1, REG_TOTAL_PIXELS, 32'd3, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h02, 1'b1, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'hAA, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h55, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h00, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h80, 1'b0, 1'b0, NoResult},
    '{1'b0, REG_COMPRESSED_MODE, 32'd0, 8'h3C, 1'b0, 1'b1, Dropped}
  };

  logic clk;
  logic rst;

  tga_in_if  in_bus ();
  tga_out_if out_bus ();
  tga_cfg_if cfg_bus ();

  tga_rle_pixel_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .data   (in_bus),
    .pixels (out_bus),
    .cfg    (cfg_bus)
  );

  bit          in_idle;
  bit          out_stall;
  bit          hold_request;
  bit          sof_next;
  int unsigned bytes_taken;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  pix_result_t expected_pixels [$];

  // Decoder shadow: settings and packet state
  logic        cfg_rle      = 1'b1;
  logic [1:0]  cfg_bpp      = 2'd1;
  logic [31:0] cfg_total    = 32'd1;
  logic        hdr_expected = 1'b1;
  logic        run_repeats  = 1'b0;
  logic [7:0]  run_left     = 8'd0;
  logic [1:0]  byte_idx     = 2'd0;
  logic [31:0] assembly     = 32'd0;
  logic [31:0] done_count   = 32'd0;
  logic        finished     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned bytes_per_pixel();
    case (cfg_bpp)
      BPP_GREY: return 1;
      BPP_BGR:  return 3;
      default:  return 4;
    endcase
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Count n copies of one pixel against the total; up to two pixels per result.
  function automatic void emit_run(input logic [31:0] pix, input logic [7:0] n);
    logic [31:0] limit;
    logic [31:0] room;
    logic [31:0] kept;
    logic [1:0]  take;
    logic        ovr;
    limit = cfg_total;
    if (limit > CountMax) limit = CountMax;
    room = (limit > done_count) ? limit - done_count : 32'd0;
    kept = ({24'd0, n} < room) ? {24'd0, n} : room;
    ovr  = kept < {24'd0, n};
    if (kept == 0) begin
      finished = done_count >= limit;
      expected_pixels.push_back('{32'd0, 32'd0, 2'd0, 1'b1, finished, 1'b1});
      return;
    end
    while (kept != 0) begin
      take = (kept >= 2) ? 2'd2 : 2'd1;
      kept -= 32'(take);
      done_count += 32'(take);
      finished = done_count >= limit;
      expected_pixels.push_back('{pix, (take == 2'd2) ? pix : 32'd0, take,
                                  kept == 0, finished, ovr});
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic sof);
    int unsigned size;
    logic [7:0]  red, green, blue, alpha;
    logic [31:0] pix;
    logic [7:0]  n;
    size = bytes_per_pixel();
    if (sof) begin
      hdr_expected = 1'b1;
      run_repeats  = 1'b0;
      run_left     = 8'd0;
      byte_idx     = 2'd0;
      assembly     = 32'd0;
      done_count   = 32'd0;
      finished     = 1'b0;
    end
    if (cfg_rle && hdr_expected) begin
      run_left     = (b & HdrRunMask) + 8'd1;
      run_repeats  = (b & HdrRepeatBit) != 0;
      hdr_expected = 1'b0;
      byte_idx     = 2'd0;
      assembly     = 32'd0;
      return;
    end
    assembly = assembly | (32'(b) << (8 * byte_idx));
    byte_idx = byte_idx + 2'd1;
    if (byte_idx != 2'd0 && byte_idx < size) return;
    // bytes arrive B, G, R, A
    blue  = assembly[7:0];
    green = assembly[15:8];
    red   = assembly[23:16];
    alpha = (size == 4) ? assembly[31:24] : 8'd0;
    pix   = (size == 1) ? {24'd0, blue} : {alpha, blue, green, red};
    byte_idx = 2'd0;
    assembly = 32'd0;
    if (!cfg_rle) begin
      emit_run(pix, 8'd1);
      return;
    end
    if (run_left == 0) run_left = 8'd1;
    if (run_repeats) begin
      n = run_left;
      run_left = 8'd0;
      hdr_expected = 1'b1;
      emit_run(pix, n);
      return;
    end
    run_left = run_left - 8'd1;
    if (run_left == 0) hdr_expected = 1'b1;
    emit_run(pix, 8'd1);
  endfunction

  function automatic void report_mismatch(input string what, input pix_result_t want,
                                          input pix_result_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t %s: expected first=%h second=%h count=%0d last=%b end=%b ovr=%b",
               $time, what, want.pixel_first, want.pixel_second, want.pixel_count,
               want.run_last, want.image_end, want.overrun);
      $display("%0t %s: actual   first=%h second=%h count=%0d last=%b end=%b ovr=%b",
               $time, what, got.pixel_first, got.pixel_second, got.pixel_count,
               got.run_last, got.image_end, got.overrun);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sof, input logic typed,
                           input pix_result_t want);
    int unsigned gap;
    int unsigned queued;
    gap = in_idle ? idle_len() : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.data_byte      <= b;
    in_bus.start_of_image <= sof;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    queued = expected_pixels.size();
    decode_byte(b, sof);
    // a typed-in expectation stands in for the computed one
    if (typed) begin
      while (expected_pixels.size() > queued) void'(expected_pixels.pop_back());
      expected_pixels.push_back(want);
    end
    bytes_taken++;
  endtask

  task automatic send_random_bytes(input int unsigned count);
    repeat (count) begin
      send_byte(8'($urandom_range(0, 255)), sof_next, 1'b0, NoResult);
      sof_next = 1'b0;
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_COMPRESSED_MODE: cfg_rle   = value[0];
      REG_BPP_CODE:        cfg_bpp   = value[1:0];
      REG_TOTAL_PIXELS:    cfg_total = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold input, wait for outstanding results, then let the block settle.
  task automatic drain(input int unsigned max_wait);
    int unsigned waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0 && waited < max_wait) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin : sink_pace
    int unsigned stall;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HoldCycles;
      end else if (out_stall && $urandom_range(0, 3) == 0) begin
        stall = idle_len() + 1;
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : pixel_check
    pix_result_t got;
    pix_result_t want;
    got = '{out_bus.pixel_first, out_bus.pixel_second, out_bus.pixel_count,
            out_bus.run_last, out_bus.image_end, out_bus.overrun};
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with none expected", NoResult, got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) report_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_end;
    int unsigned phase_end;
    int unsigned pix_bytes;
    int unsigned len;
    int unsigned nbytes;
    int unsigned r;
    logic        rep;
    logic [31:0] total;
    rst                   <= 1'b1;
    in_bus.valid          <= 1'b0;
    in_bus.data_byte      <= 8'd0;
    in_bus.start_of_image <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= REG_COMPRESSED_MODE;
    cfg_bus.data          <= 32'd0;
    in_idle   = 1'b1;
    out_stall = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].is_cfg) begin
        drain(CycleLimit);
        write_reg(DirectedRows[i].reg_idx, DirectedRows[i].value);
      end else begin
        send_byte(DirectedRows[i].data_byte, DirectedRows[i].sof,
                  DirectedRows[i].typed, DirectedRows[i].want);
      end
    end

    // Long receiver hold-off behind back-to-back repeat runs fills the block.
    drain(CycleLimit);
    write_reg(REG_COMPRESSED_MODE, 32'd1);
    write_reg(REG_BPP_CODE, 32'(BPP_GREY));
    write_reg(REG_TOTAL_PIXELS, 32'd1000);
    in_idle = 1'b0;
    sof_next = 1'b1;
    hold_request = 1'b1;
    repeat (4) begin
      send_byte(8'hFF, sof_next, 1'b0, NoResult);
      sof_next = 1'b0;
      send_random_bytes(1);
    end

    random_end = bytes_taken + RandomItems;
    while (bytes_taken < random_end) begin
      drain(CycleLimit);
      write_reg(REG_COMPRESSED_MODE, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
      write_reg(REG_BPP_CODE, 32'($urandom_range(0, 3)));
      r = $urandom_range(0, 9);
      if (r == 0) total = 32'd0;
      else if (r == 1) total = 32'hFFFF_FFFF;
      else if (r == 2) total = $urandom;
      else total = $urandom_range(1, 80);
      write_reg(REG_TOTAL_PIXELS, total);
      in_idle   = $urandom_range(0, 3) != 0;
      out_stall = $urandom_range(0, 3) != 0;
      sof_next  = $urandom_range(0, 7) != 0;
      phase_end = bytes_taken + $urandom_range(15, 60);
      while (bytes_taken < phase_end) begin
        pix_bytes = bytes_per_pixel();
        if ($urandom_range(0, 9) == 0) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, 1'b0, NoResult);
        end else if (cfg_rle) begin
          rep = $urandom_range(0, 1);
          if (rep) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 128) : $urandom_range(1, 12);
          end else begin
            len = (cfg_bpp == BPP_GREY && $urandom_range(0, 29) == 0) ? 128 :
                  $urandom_range(1, 5);
          end
          send_byte({rep, 7'(len - 1)}, sof_next, 1'b0, NoResult);
          sof_next = 1'b0;
          nbytes = rep ? pix_bytes : len * pix_bytes;
          // cut the packet short now and then
          if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes - 1);
          send_random_bytes(nbytes);
        end else begin
          send_random_bytes(pix_bytes);
        end
      end
    end

    drain(20000);
    if (expected_pixels.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", expected_pixels.size());
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tga_pkg.sv
hw/rtl/tga_in_if.sv
hw/rtl/tga_out_if.sv
hw/rtl/tga_cfg_if.sv
hw/rtl/tga_ctrl.sv
hw/rtl/tga_dp.sv
hw/rtl/tga_rle_pixel_decoder.sv
dv/tga_rle_pixel_decoder_test.sv
